[rtl/enc_pkg.sv]
// ----------------------------------------------------------------------------
// enc_pkg
// Shared types and constants for the edge-normalized convolution block.
// ----------------------------------------------------------------------------
package enc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int WEIGHT_BITS = 16;
    localparam int TAP_BITS    = 6;
    localparam int HALF_BITS   = 5;
    localparam int SEEN_BITS   = 7;
    // Ceilings that cover the whole half-width parameter range (up to 63)
    localparam int LAG_BITS    = 6;
    localparam int PTR_BITS    = 7;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

    localparam logic [SEEN_BITS-1:0] SEEN_MAX = 7'd127;

    typedef struct packed {
        logic                          command;
        logic [TAP_BITS-1:0]           tap_index;
        logic [WEIGHT_BITS-1:0]        weight;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic                          last_result;
    } t_out_item;

    // One output to compute: centre lag, half width, window fill, newest slot
    typedef struct packed {
        logic [LAG_BITS-1:0]  lag;
        logic [LAG_BITS-1:0]  half;
        logic [SEEN_BITS-1:0] newest;
        logic [PTR_BITS-1:0]  base;
        logic                 last;
    } t_job;

    // Memory writes issued by the front end
    typedef struct packed {
        logic                          wt_en;
        logic [PTR_BITS-1:0]           wt_addr;
        logic [WEIGHT_BITS-1:0]        weight;
        logic                          smp_en;
        logic [PTR_BITS-1:0]           smp_addr;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_mem_wr;

    typedef enum logic {
        FS_IDLE,
        FS_FLUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MAC,
        BS_DRAIN,
        BS_DIV,
        BS_OUT
    } t_back_state;

endpackage

[rtl/enc_front.sv]
// ----------------------------------------------------------------------------
// enc_front
// Accepts items, issues weight and sample writes, and queues output jobs.
// ----------------------------------------------------------------------------
module enc_front #(
    parameter int MAX_HALF = 31
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  enc_pkg::t_in_item               i_in_item,
    output logic                            o_in_stall,
    input  logic [enc_pkg::HALF_BITS-1:0]   i_half_width,
    input  logic                            i_pending,
    output enc_pkg::t_mem_wr                o_wr,
    output logic                            o_job_valid,
    output enc_pkg::t_job                   o_job,
    input  logic                            i_job_full
);

    localparam int SLOTS = 2 * MAX_HALF + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam int HW    = $clog2(MAX_HALF + 1);

    enc_pkg::t_front_state              r_state, n_state;
    logic [enc_pkg::SEEN_BITS-1:0]      r_seen, n_seen;
    logic [AW-1:0]                      r_wptr, n_wptr;
    logic [HW-1:0]                      r_lag, n_lag;
    enc_pkg::t_job                      r_ctx, n_ctx;

    logic          w_accept, w_push, w_load, w_main;
    logic [HW-1:0] w_h, w_top;

    // Clamp the half width to the parameter ceiling
    assign w_h = (int'(i_half_width) > MAX_HALF) ? HW'(MAX_HALF) : HW'(i_half_width);

    assign o_in_stall = (r_state != enc_pkg::FS_IDLE) || i_pending;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_push     = w_accept && (i_in_item.command == enc_pkg::CMD_PUSH);
    assign w_load     = w_accept && (i_in_item.command == enc_pkg::CMD_LOAD);
    assign w_main     = w_push && (r_seen >= enc_pkg::SEEN_BITS'(w_h));

    // Newest flushed lag: min(h-1, samples held before this one)
    always_comb begin
        if ((enc_pkg::SEEN_BITS'(w_h) - 7'd1) < r_seen) begin
            w_top = w_h - 1'b1;
        end else begin
            w_top = HW'(r_seen);
        end
    end

    // Memory writes
    always_comb begin
        o_wr.wt_en    = w_load && (int'(i_in_item.tap_index) < SLOTS);
        o_wr.wt_addr  = enc_pkg::PTR_BITS'(i_in_item.tap_index);
        o_wr.weight   = i_in_item.weight;
        o_wr.smp_en   = w_push;
        o_wr.smp_addr = enc_pkg::PTR_BITS'(r_wptr + 1'b1);
        o_wr.sample   = i_in_item.sample;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            enc_pkg::FS_IDLE: begin
                if (w_push && i_in_item.last_sample && (w_h != '0)) begin
                    n_state = enc_pkg::FS_FLUSH;
                end
            end
            enc_pkg::FS_FLUSH: begin
                if (!i_job_full && (r_lag == '0)) begin
                    n_state = enc_pkg::FS_IDLE;
                end
            end
            default: n_state = enc_pkg::FS_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        o_job_valid = 1'b0;
        o_job       = r_ctx;
        n_seen      = r_seen;
        n_wptr      = r_wptr;
        n_lag       = r_lag;
        n_ctx       = r_ctx;
        unique case (r_state)
            enc_pkg::FS_IDLE: begin
                o_job.lag    = enc_pkg::LAG_BITS'(w_h);
                o_job.half   = enc_pkg::LAG_BITS'(w_h);
                o_job.newest = r_seen;
                o_job.base   = enc_pkg::PTR_BITS'(r_wptr + 1'b1);
                o_job.last   = i_in_item.last_sample && (w_h == '0);
                o_job_valid  = w_main;
                if (w_push) begin
                    n_wptr = r_wptr + 1'b1;
                    n_ctx  = o_job;
                    n_lag  = w_top;
                    if (i_in_item.last_sample) begin
                        n_seen = '0;
                    end else if (r_seen != enc_pkg::SEEN_MAX) begin
                        n_seen = r_seen + 1'b1;
                    end
                end
            end
            enc_pkg::FS_FLUSH: begin
                o_job.lag   = enc_pkg::LAG_BITS'(r_lag);
                o_job.last  = (r_lag == '0);
                o_job_valid = !i_job_full;
                if (!i_job_full && (r_lag != '0)) begin
                    n_lag = r_lag - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= enc_pkg::FS_IDLE;
            r_seen  <= '0;
            r_wptr  <= '0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_wptr  <= n_wptr;
        end
        r_lag <= n_lag;
        r_ctx <= n_ctx;
    end

endmodule

[rtl/enc_queue.sv]
// ----------------------------------------------------------------------------
// enc_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module enc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  enc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output enc_pkg::t_job o_job
);

    enc_pkg::t_job r_entry [2];
    logic          r_rd, r_wr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_entry[r_rd];

    // Store new jobs
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_entry[r_wr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= ~r_wr;
            end
            if (i_pop && !o_empty) begin
                r_rd <= ~r_rd;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/enc_back.sv]
// ----------------------------------------------------------------------------
// enc_back
// Holds weights and samples, runs the tap MAC and the serial divider.
// ----------------------------------------------------------------------------
module enc_back #(
    parameter int MAX_HALF = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  enc_pkg::t_mem_wr  i_wr,
    input  logic              i_job_valid,
    input  enc_pkg::t_job     i_job,
    output logic              o_job_pop,
    output logic              o_busy,
    output logic              o_out_valid,
    output enc_pkg::t_out_item o_out_item,
    input  logic              i_out_stall
);

    localparam int SLOTS = 2 * MAX_HALF + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam int DEPTH = 2 ** AW;
    localparam int DW    = AW + 2;
    localparam int SB    = enc_pkg::SAMPLE_BITS;
    localparam int WB    = enc_pkg::WEIGHT_BITS;
    localparam int PW    = SB + WB + 1;
    localparam int ACC_W = SB + WB + AW;
    localparam int WS_W  = WB + AW;
    localparam int CW    = $clog2(ACC_W + 1);

    logic [WB-1:0]        r_wt  [SLOTS];
    logic signed [SB-1:0] r_win [DEPTH];

    enc_pkg::t_back_state r_state, n_state;
    enc_pkg::t_job        r_job;
    logic [AW-1:0]        r_t;
    logic [WB-1:0]        r_wt_rd, r_pw;
    logic signed [SB-1:0] r_smp_rd;
    logic                 r_v1, r_v2;
    logic signed [PW-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [WS_W-1:0]      r_wsum;
    logic [ACC_W-1:0]     r_dvd;
    logic [WS_W:0]        r_rem;
    logic [CW-1:0]        r_cnt;
    logic                 r_neg;
    logic                 r_out_valid;
    enc_pkg::t_out_item   r_out;

    logic signed [DW-1:0] w_d;
    logic                 w_in, w_issue, w_last_tap, w_load_out, w_drained;
    logic [AW-1:0]        w_addr;
    logic [WS_W:0]        w_rem_sh;
    logic                 w_qbit;
    logic [ACC_W-1:0]     w_q;

    // Tap offset into the window and in-range test
    assign w_d        = DW'(r_job.lag) + DW'(r_job.half) - DW'(r_t);
    assign w_in       = !w_d[DW-1] && (int'(w_d) <= int'(r_job.newest));
    assign w_addr     = r_job.base[AW-1:0] - w_d[AW-1:0];
    assign w_issue    = (r_state == enc_pkg::BS_MAC);
    assign w_last_tap = (r_t == AW'({r_job.half, 1'b0}));
    assign w_drained  = !r_v1 && !r_v2;

    // One restoring division step
    assign w_rem_sh = {r_rem[WS_W-1:0], r_dvd[ACC_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_wsum});
    assign w_q      = r_neg ? (~r_dvd + 1'b1) : r_dvd;

    assign w_load_out = (r_state == enc_pkg::BS_OUT) && (!r_out_valid || !i_out_stall);

    assign o_busy      = (r_state != enc_pkg::BS_IDLE);
    assign o_job_pop   = (r_state == enc_pkg::BS_IDLE) && i_job_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Write and read the weight and sample memories
    always_ff @(posedge i_clk) begin
        if (i_wr.wt_en) begin
            r_wt[i_wr.wt_addr[AW-1:0]] <= i_wr.weight;
        end
        if (i_wr.smp_en) begin
            r_win[i_wr.smp_addr[AW-1:0]] <= i_wr.sample;
        end
        r_wt_rd  <= r_wt[r_t];
        r_smp_rd <= r_win[w_addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            enc_pkg::BS_IDLE:  if (i_job_valid) n_state = enc_pkg::BS_MAC;
            enc_pkg::BS_MAC:   if (w_last_tap) n_state = enc_pkg::BS_DRAIN;
            enc_pkg::BS_DRAIN: begin
                if (w_drained) begin
                    n_state = (r_wsum == '0) ? enc_pkg::BS_OUT : enc_pkg::BS_DIV;
                end
            end
            enc_pkg::BS_DIV: begin
                if (r_cnt == CW'(ACC_W - 1)) n_state = enc_pkg::BS_OUT;
            end
            enc_pkg::BS_OUT:   if (w_load_out) n_state = enc_pkg::BS_IDLE;
            default:           n_state = enc_pkg::BS_IDLE;
        endcase
    end

    // Datapath: MAC pipeline, divider and output register
    always_ff @(posedge i_clk) begin
        r_v1   <= w_issue && w_in;
        r_v2   <= r_v1;
        r_prod <= PW'(r_smp_rd * $signed({1'b0, r_wt_rd}));
        r_pw   <= r_wt_rd;

        unique case (r_state)
            enc_pkg::BS_IDLE: begin
                r_job  <= i_job;
                r_t    <= '0;
                r_acc  <= '0;
                r_wsum <= '0;
            end
            enc_pkg::BS_MAC: begin
                r_t <= r_t + 1'b1;
            end
            enc_pkg::BS_DRAIN: begin
                r_neg <= r_acc[ACC_W-1];
                r_dvd <= (r_wsum == '0) ? '0 :
                         (r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc));
                r_rem <= '0;
                r_cnt <= '0;
            end
            enc_pkg::BS_DIV: begin
                r_rem <= w_qbit ? (w_rem_sh - {1'b0, r_wsum}) : w_rem_sh;
                r_dvd <= {r_dvd[ACC_W-2:0], w_qbit};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase

        // Accumulate products and weights as they leave the pipeline
        if (r_v2) begin
            r_acc  <= r_acc + ACC_W'(r_prod);
            r_wsum <= r_wsum + WS_W'(r_pw);
        end

        if (w_load_out) begin
            r_out.smoothed    <= w_q[SB-1:0];
            r_out.last_result <= r_job.last;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= enc_pkg::BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[rtl/edge_normalized_convolution.sv]
// ----------------------------------------------------------------------------
// edge_normalized_convolution
// Smoother over H samples either side, renormalized by the in-range weight sum.
// ----------------------------------------------------------------------------
// Load items write kernel weights; push items add a sample and produce the
// output H samples back, and a last sample flushes the remaining outputs.
// Items are handled one at a time. Each output takes its job from the queue,
// runs the tap multiply-accumulate (one weight and one sample memory read per
// cycle), drains the product pipeline, runs the one-bit-per-cycle division
// unless the weight sum is zero, and loads the output register once the
// output side is not stalled. The next item is taken once all outputs of the
// current one are computed. The half width register has its own always-ready
// port; it must be written only while idle, which the block does not enforce.
module edge_normalized_convolution #(
    parameter int MAX_HALF = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  enc_pkg::t_in_item             i_in_item,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output enc_pkg::t_out_item            o_out_item,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [enc_pkg::HALF_BITS-1:0] i_cfg_data
);

    logic [enc_pkg::HALF_BITS-1:0] r_half_width;
    enc_pkg::t_mem_wr              w_wr;
    enc_pkg::t_job                 w_push_job, w_pop_job;
    logic w_push, w_full, w_pop, w_empty, w_busy;

    assign o_cfg_ready = 1'b1;

    // Hold the half width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half_width <= i_cfg_data;
        end
    end

    enc_front #(.MAX_HALF(MAX_HALF)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_half_width (r_half_width),
        .i_pending    (w_busy || !w_empty),
        .o_wr         (w_wr),
        .o_job_valid  (w_push),
        .o_job        (w_push_job),
        .i_job_full   (w_full)
    );

    enc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_pop_job)
    );

    enc_back #(.MAX_HALF(MAX_HALF)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_job_valid (!w_empty),
        .i_job       (w_pop_job),
        .o_job_pop   (w_pop),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

[rtl/enc_checker.sv]
// ----------------------------------------------------------------------------
// enc_checker
// Port-level checks for the edge-normalized convolution block.
// ----------------------------------------------------------------------------
module enc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input enc_pkg::t_out_item o_out_item
);

    // Drop the output valid right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid not cleared by reset");

    // Hold a stalled output transaction
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("output payload changed while stalled");

    // A new result only appears while the input side is held off
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while input side was idle");

endmodule

bind edge_normalized_convolution enc_checker u_enc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for edge_normalized_convolution. Loads kernel weights and pushes
// sample spectra, predicts every smoothed output, and checks each transaction
// field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAP_SLOTS  = 63;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 200;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    enc_pkg::t_in_item             i_in_item;
    logic                          o_in_stall;
    logic                          o_out_valid;
    enc_pkg::t_out_item            o_out_item;
    logic                          i_out_stall;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [enc_pkg::HALF_BITS-1:0] i_cfg_data;

    // Predictor state
    logic [enc_pkg::WEIGHT_BITS-1:0]        kernel_weights [TAP_SLOTS];
    logic signed [enc_pkg::SAMPLE_BITS-1:0] recent_samples [TAP_SLOTS];
    int                                     spectrum_fill;
    int                                     kernel_half;
    enc_pkg::t_out_item                     expected_smooth [$];

    int  error_count;
    int  items_sent;
    int  results_seen;
    int  idle_cycles;
    int  spectra_sent;
    bit  gaps_on;

    edge_normalized_convolution DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Generate clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Count and print one mismatch
    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Append one predicted output at the tail
    task automatic queue_result(input enc_pkg::t_out_item res);
        expected_smooth = {expected_smooth, res};
    endtask

    // Weighted in-range average around the sample lag steps back
    function automatic logic signed [enc_pkg::SAMPLE_BITS-1:0] smooth_at(input int lag,
                                                                         input int h,
                                                                         input int newest);
        longint acc;
        longint wsum;
        int     d;
        acc  = 0;
        wsum = 0;
        for (int t = 0; t <= 2 * h; t++) begin
            d = lag + h - t;
            if (d < 0 || d > newest || d >= TAP_SLOTS) continue;
            acc  += longint'(recent_samples[d]) * longint'(kernel_weights[t]);
            wsum += longint'(kernel_weights[t]);
        end
        if (wsum == 0) return '0;
        return enc_pkg::SAMPLE_BITS'(acc / wsum);
    endfunction

    // Update predictor state and queue the outputs one transaction causes
    task automatic predict_outputs(input enc_pkg::t_in_item it);
        int                 newest;
        int                 top;
        int                 first;
        enc_pkg::t_out_item res;
        if (it.command == enc_pkg::CMD_LOAD) begin
            if (it.tap_index < TAP_SLOTS) kernel_weights[it.tap_index] = it.weight;
            return;
        end
        newest = spectrum_fill;
        first  = expected_smooth.size();
        for (int k = TAP_SLOTS - 1; k > 0; k--) recent_samples[k] = recent_samples[k-1];
        recent_samples[0] = it.sample;
        if (spectrum_fill < 127) spectrum_fill++;
        if (newest >= kernel_half) begin
            res.smoothed    = smooth_at(kernel_half, kernel_half, newest);
            res.last_result = 1'b0;
            queue_result(res);
        end
        if (it.last_sample) begin
            top = (kernel_half - 1 < newest) ? kernel_half - 1 : newest;
            for (int lag = top; lag >= 0; lag--) begin
                res.smoothed    = smooth_at(lag, kernel_half, newest);
                res.last_result = 1'b0;
                queue_result(res);
            end
            if (expected_smooth.size() > first)
                expected_smooth[expected_smooth.size()-1].last_result = 1'b1;
            spectrum_fill = 0;
            spectra_sent++;
        end
    endtask

    // Drive one transaction, with random gaps, and predict once accepted
    task automatic send_item(input enc_pkg::t_in_item it);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            i_in_item  <= enc_pkg::t_in_item'($bits(enc_pkg::t_in_item)'(
                              {$urandom(), $urandom()}));
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        predict_outputs(it);
    endtask

    function automatic enc_pkg::t_in_item load_item(input int slot, input int w);
        enc_pkg::t_in_item it;
        it           = enc_pkg::t_in_item'($bits(enc_pkg::t_in_item)'({$urandom(), $urandom()}));
        it.command   = enc_pkg::CMD_LOAD;
        it.tap_index = enc_pkg::TAP_BITS'(slot);
        it.weight    = enc_pkg::WEIGHT_BITS'(w);
        return it;
    endfunction

    function automatic enc_pkg::t_in_item push_item(input int s, input bit last);
        enc_pkg::t_in_item it;
        it             = enc_pkg::t_in_item'($bits(enc_pkg::t_in_item)'({$urandom(), $urandom()}));
        it.command     = enc_pkg::CMD_PUSH;
        it.sample      = enc_pkg::SAMPLE_BITS'(s);
        it.last_sample = last;
        return it;
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(0, 7))
            0:       return -8388608;
            1:       return 8388607;
            default: return int'($urandom()) >>> 8;
        endcase
    endfunction

    // Release the input channel and wait until every output has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_smooth.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write the half width while the block is idle
    task automatic write_half(input int h);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= enc_pkg::HALF_BITS'(h);
        do @(posedge i_clk); while (!o_cfg_ready);
        kernel_half = h;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_spectrum(input int len);
        for (int k = 0; k < len; k++) send_item(push_item(rand_sample(), k == len - 1));
    endtask

    task automatic load_kernel_all();
        for (int s = 0; s < TAP_SLOTS; s++)
            send_item(load_item(s, (s == 0) ? 65535 : (s == 1) ? 0 : $urandom_range(0, 65535)));
        // Slot past the kernel is dropped
        send_item(load_item(63, 12345));
    endtask

    // Extremes of samples, short spectra and a full-width kernel
    task automatic test_directed();
        write_half(31);
        load_kernel_all();
        send_item(push_item(8388607, 1'b0));
        send_item(push_item(-8388608, 1'b0));
        send_item(push_item(0, 1'b1));
        send_item(push_item(-1, 1'b1));
        write_half(0);
        send_item(push_item(8388607, 1'b0));
        send_item(push_item(-8388608, 1'b1));
        write_half(2);
        send_spectrum(6);
    endtask

    // Kernel of zero weights yields zero everywhere, then a zero centre weight
    task automatic test_zero_weights();
        write_half(2);
        for (int s = 0; s < 5; s++) send_item(load_item(s, 0));
        send_spectrum(3);
        for (int s = 0; s < 5; s++) send_item(load_item(s, (s == 2) ? 0 : 40000));
        send_spectrum(4);
    endtask

    // Switch the half width in the middle of a spectrum
    task automatic test_half_change();
        write_half(3);
        for (int k = 0; k < 5; k++) send_item(push_item(rand_sample(), 1'b0));
        write_half(1);
        send_item(push_item(rand_sample(), 1'b0));
        write_half(5);
        send_item(push_item(rand_sample(), 1'b0));
        send_item(push_item(rand_sample(), 1'b1));
    endtask

    // Stream a spectrum with no idling on either side
    task automatic test_no_gaps();
        write_half(1);
        gaps_on = 1'b0;
        send_spectrum(16);
        gaps_on = 1'b1;
    endtask

    // Random spectra at random half widths with loads mixed in
    task automatic test_random();
        int budget;
        int len;
        budget = 12;
        while (budget > 0) begin
            write_half(($urandom_range(0, 9) == 0) ? 31 : $urandom_range(0, 6));
            repeat ($urandom_range(1, 3)) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(load_item($urandom_range(0, 63), $urandom_range(0, 65535)));
                    send_item(push_item(rand_sample(), k == len - 1));
                    budget--;
                end
            end
        end
    endtask

    // Drive the output stall
    always @(negedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(0, 99) < 6);
    end

    // Check each output transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_smooth.size() == 0) begin
                report_mismatch($sformatf("unexpected output %0d", o_out_item.smoothed));
            end else begin
                if (o_out_item.smoothed !== expected_smooth[0].smoothed)
                    report_mismatch($sformatf("smoothed %0d, expected %0d",
                        o_out_item.smoothed, expected_smooth[0].smoothed));
                if (o_out_item.last_result !== expected_smooth[0].last_result)
                    report_mismatch($sformatf("last_result %0b, expected %0b",
                        o_out_item.last_result, expected_smooth[0].last_result));
                void'(expected_smooth.pop_front());
            end
        end
    end

    // Watchdog: end the run after too long without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        error_count   = 0;
        items_sent    = 0;
        results_seen  = 0;
        idle_cycles   = 0;
        spectra_sent  = 0;
        spectrum_fill = 0;
        kernel_half   = 0;
        gaps_on       = 1'b1;
        foreach (kernel_weights[k]) kernel_weights[k] = '0;
        foreach (recent_samples[k]) recent_samples[k] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_zero_weights();
        test_half_change();
        test_no_gaps();
        test_random();
        wait_idle();

        $display("Sent %0d items in %0d spectra; checked %0d smoothed outputs",
                 items_sent, spectra_sent, results_seen);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[edge_normalized_convolution.f]
rtl/enc_pkg.sv
rtl/enc_front.sv
rtl/enc_queue.sv
rtl/enc_back.sv
rtl/edge_normalized_convolution.sv
rtl/enc_checker.sv
dv/tb_top.sv
